@@ src/mbtcp_pkg.sv @@
// shared types and constants of the modbus tcp holding register server
`timescale 1ns / 1ps
package mbtcp_pkg;

    localparam logic [7:0] FC_READ       = 8'h03;
    localparam logic [7:0] FC_WRITE_ONE  = 8'h06;
    localparam logic [7:0] FC_WRITE_MANY = 8'h10;
    localparam logic [7:0] EXC_FUNCTION  = 8'h01;
    localparam logic [7:0] EXC_ADDRESS   = 8'h02;
    localparam logic [7:0] EXC_FLAG      = 8'h80;
    localparam logic [7:0] BROADCAST_ID  = 8'hFF;
    localparam logic [7:0] UNIT_RESET    = 8'h01;
    localparam int         HDR_BYTES     = 13;
    localparam logic [8:0] MIN_FRAME     = 9'd8;
    localparam logic [8:0] QTY_FRAME     = 9'd12;
    localparam logic [8:0] LEN_MAX       = 9'd511;
    localparam logic [8:0] WM_DATA_START = 9'd13;
    localparam logic [3:0] TX_SHORT      = 4'd9;
    localparam logic [3:0] TX_LONG       = 4'd12;

    typedef enum logic [3:0] {
        S_RX,
        S_DEC,
        S_HDR,
        S_RD_REQ,
        S_RD_CAP,
        S_RD_HI,
        S_RD_LO,
        S_WM_RDHI,
        S_WM_RDLO,
        S_WM_WR
    } t_state;

    typedef enum logic [1:0] {
        K_READ,
        K_WRITE,
        K_EXC
    } t_kind;

endpackage

@@ src/mbtcp_ram.sv @@
// generic single write port ram with registered read
`timescale 1ns / 1ps
module mbtcp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                                       i_clk,
    input  logic                                       i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                           i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                           o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

@@ src/modbus_tcp_holding_register_server_unit.sv @@
// top level: modbus tcp holding register server
// channel | dir | tdata             | tlast
// s       | in  | rx_byte [7:0]     | rx_last
// m       | out | tx_byte [7:0]     | tx_last
// cfg     | in  | unit_address[7:0] | -
// one request byte per cycle; after the last byte a decode state, then the response
// header bytes; each register read passes the holding ram read, capture and two
// byte states; write multiple reads two frame ram bytes, then writes, per register.
// no request byte is taken while a response is built; output stalls hold the fsm.
// reset clears the holding registers through per-entry valid bits, no sweep.
`timescale 1ns / 1ps
module modbus_tcp_holding_register_server_unit #(
    parameter int HOLDING_DEPTH = 16,
    parameter int FRAME_BYTES   = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_tvalid,
    output logic       o_s_tready,
    input  logic [7:0] i_s_tdata,   // rx_byte
    input  logic       i_s_tlast,
    output logic       o_m_tvalid,
    input  logic       i_m_tready,
    output logic [7:0] o_m_tdata,   // tx_byte
    output logic       o_m_tlast,
    input  logic       i_cfg_wr_en,
    input  logic [7:0] i_cfg_wr_data
);

    localparam int HA = (HOLDING_DEPTH > 1) ? $clog2(HOLDING_DEPTH) : 1;
    localparam int CW = $clog2(HOLDING_DEPTH + 1);
    localparam int FW = $clog2(FRAME_BYTES);

    mbtcp_pkg::t_state r_state, n_state;
    mbtcp_pkg::t_kind  r_kind, n_kind;

    logic [7:0]  r_unit;
    logic [8:0]  r_len, n_len;
    logic [7:0]  r_hdr [mbtcp_pkg::HDR_BYTES];
    logic [7:0]  hb [mbtcp_pkg::HDR_BYTES];
    logic [3:0]  r_k, n_k;
    logic [3:0]  r_tx_n, n_tx_n;
    logic [7:0]  r_exc, n_exc;
    logic [HA-1:0] r_ptr, n_ptr;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [8:0]  r_fidx, n_fidx;
    logic        r_fok, n_fok;
    logic        r_hvq, n_hvq;
    logic [7:0]  r_hi, n_hi;
    logic [15:0] r_word, n_word;
    logic [HOLDING_DEPTH-1:0] r_hvalid;

    logic        in_acc;
    logic        f_we;
    logic [7:0]  f_rdata;
    logic        h_we;
    logic [HA-1:0] h_waddr;
    logic [15:0] h_wdata, h_rdata;
    logic        emit, emit_last, out_free;
    logic [7:0]  emit_byte, resp;
    logic [15:0] addr, qty;
    logic [6:0]  wcount;
    logic [7:0]  fc;
    logic [7:0]  f_masked;

    mbtcp_ram #(.WIDTH(8), .DEPTH(FRAME_BYTES)) u_frame (
        .i_clk   (i_clk),
        .i_we    (f_we),
        .i_waddr (r_len[FW-1:0]),
        .i_wdata (i_s_tdata),
        .i_raddr (r_fidx[FW-1:0]),
        .o_rdata (f_rdata)
    );

    mbtcp_ram #(.WIDTH(16), .DEPTH(HOLDING_DEPTH)) u_hold (
        .i_clk   (i_clk),
        .i_we    (h_we),
        .i_waddr (h_waddr),
        .i_wdata (h_wdata),
        .i_raddr (r_ptr),
        .o_rdata (h_rdata)
    );

    assign o_s_tready = (r_state == mbtcp_pkg::S_RX);
    assign in_acc     = i_s_tvalid && o_s_tready;
    assign f_we       = in_acc && (r_len < 9'(FRAME_BYTES));
    assign out_free   = !o_m_tvalid || i_m_tready;
    assign f_masked   = r_fok ? f_rdata : 8'h00;

    always_comb begin
        for (int i = 0; i < mbtcp_pkg::HDR_BYTES; i++) begin
            hb[i] = (9'(i) < r_len) ? r_hdr[i] : 8'h00;
        end
    end

    assign fc     = hb[7];
    assign addr   = {hb[8], hb[9]};
    assign qty    = (r_len >= mbtcp_pkg::QTY_FRAME) ? {hb[10], hb[11]} : 16'h0000;
    assign wcount = hb[12][7:1];

    always_comb begin
        case (r_k)
            4'd4: resp = 8'h00;
            4'd5: begin
                case (r_kind)
                    mbtcp_pkg::K_EXC:  resp = 8'd3;
                    mbtcp_pkg::K_READ: resp = 8'(r_tx_n) + 8'({r_cnt, 1'b0}) - 8'd6;
                    default:           resp = 8'd6;
                endcase
            end
            4'd7: resp = (r_kind == mbtcp_pkg::K_EXC) ? (hb[7] | mbtcp_pkg::EXC_FLAG) : hb[7];
            4'd8: begin
                case (r_kind)
                    mbtcp_pkg::K_EXC:  resp = r_exc;
                    mbtcp_pkg::K_READ: resp = 8'({r_cnt, 1'b0});
                    default:           resp = hb[8];
                endcase
            end
            default: resp = (r_k < 4'(mbtcp_pkg::HDR_BYTES)) ? hb[r_k] : 8'h00;
        endcase
    end

    always_comb begin
        n_state   = r_state;
        n_kind    = r_kind;
        n_len     = r_len;
        n_k       = r_k;
        n_tx_n    = r_tx_n;
        n_exc     = r_exc;
        n_ptr     = r_ptr;
        n_cnt     = r_cnt;
        n_fidx    = r_fidx;
        n_fok     = r_fok;
        n_hvq     = r_hvq;
        n_hi      = r_hi;
        n_word    = r_word;
        emit      = 1'b0;
        emit_byte = 8'h00;
        emit_last = 1'b0;
        h_we      = 1'b0;
        h_waddr   = r_ptr;
        h_wdata   = {r_hi, f_masked};
        case (r_state)
            mbtcp_pkg::S_RX: begin
                if (in_acc) begin
                    if (r_len != mbtcp_pkg::LEN_MAX) begin
                        n_len = r_len + 9'd1;
                    end
                    if (i_s_tlast) begin
                        n_state = mbtcp_pkg::S_DEC;
                    end
                end
            end
            mbtcp_pkg::S_DEC: begin
                n_k    = 4'd0;
                n_exc  = mbtcp_pkg::EXC_ADDRESS;
                n_kind = mbtcp_pkg::K_EXC;
                n_tx_n = mbtcp_pkg::TX_SHORT;
                n_state = mbtcp_pkg::S_HDR;
                n_cnt  = '0;
                n_ptr  = addr[HA-1:0];
                n_fidx = mbtcp_pkg::WM_DATA_START;
                if (r_len < mbtcp_pkg::MIN_FRAME ||
                    (hb[6] != r_unit && hb[6] != mbtcp_pkg::BROADCAST_ID)) begin
                    n_state = mbtcp_pkg::S_RX;
                    n_len   = 9'd0;
                end else begin
                    case (fc)
                        mbtcp_pkg::FC_READ: begin
                            if ({1'b0, addr} + {1'b0, qty} <= 17'(HOLDING_DEPTH)) begin
                                n_kind = mbtcp_pkg::K_READ;
                                n_cnt  = CW'(qty);
                            end
                        end
                        mbtcp_pkg::FC_WRITE_ONE: begin
                            if ({1'b0, addr} < 17'(HOLDING_DEPTH)) begin
                                n_kind  = mbtcp_pkg::K_WRITE;
                                n_tx_n  = mbtcp_pkg::TX_LONG;
                                h_we    = 1'b1;
                                h_waddr = addr[HA-1:0];
                                h_wdata = {hb[10], hb[11]};
                            end
                        end
                        mbtcp_pkg::FC_WRITE_MANY: begin
                            if ({1'b0, addr} + 17'(wcount) <= 17'(HOLDING_DEPTH)) begin
                                n_kind = mbtcp_pkg::K_WRITE;
                                n_tx_n = mbtcp_pkg::TX_LONG;
                                n_cnt  = CW'(wcount);
                                if (wcount != 7'd0) begin
                                    n_state = mbtcp_pkg::S_WM_RDHI;
                                end
                            end
                        end
                        default: begin
                            n_exc = mbtcp_pkg::EXC_FUNCTION;
                        end
                    endcase
                end
            end
            mbtcp_pkg::S_WM_RDHI: begin
                n_fok   = (r_fidx < r_len) && (r_fidx < 9'(FRAME_BYTES));
                n_fidx  = r_fidx + 9'd1;
                n_state = mbtcp_pkg::S_WM_RDLO;
            end
            mbtcp_pkg::S_WM_RDLO: begin
                n_hi    = f_masked;
                n_fok   = (r_fidx < r_len) && (r_fidx < 9'(FRAME_BYTES));
                n_fidx  = r_fidx + 9'd1;
                n_state = mbtcp_pkg::S_WM_WR;
            end
            mbtcp_pkg::S_WM_WR: begin
                h_we  = 1'b1;
                n_ptr = r_ptr + HA'(1);
                n_cnt = r_cnt - CW'(1);
                n_state = (r_cnt == CW'(1)) ? mbtcp_pkg::S_HDR : mbtcp_pkg::S_WM_RDHI;
            end
            mbtcp_pkg::S_HDR: begin
                if (out_free) begin
                    emit      = 1'b1;
                    emit_byte = resp;
                    emit_last = (r_k == r_tx_n - 4'd1) &&
                                !(r_kind == mbtcp_pkg::K_READ && r_cnt != '0);
                    n_k = r_k + 4'd1;
                    if (r_k == r_tx_n - 4'd1) begin
                        if (emit_last) begin
                            n_state = mbtcp_pkg::S_RX;
                            n_len   = 9'd0;
                        end else begin
                            n_state = mbtcp_pkg::S_RD_REQ;
                        end
                    end
                end
            end
            mbtcp_pkg::S_RD_REQ: begin
                n_hvq   = r_hvalid[r_ptr];
                n_state = mbtcp_pkg::S_RD_CAP;
            end
            mbtcp_pkg::S_RD_CAP: begin
                n_word  = r_hvq ? h_rdata : 16'h0000;
                n_state = mbtcp_pkg::S_RD_HI;
            end
            mbtcp_pkg::S_RD_HI: begin
                if (out_free) begin
                    emit      = 1'b1;
                    emit_byte = r_word[15:8];
                    n_state   = mbtcp_pkg::S_RD_LO;
                end
            end
            mbtcp_pkg::S_RD_LO: begin
                if (out_free) begin
                    emit      = 1'b1;
                    emit_byte = r_word[7:0];
                    emit_last = (r_cnt == CW'(1));
                    n_ptr     = r_ptr + HA'(1);
                    n_cnt     = r_cnt - CW'(1);
                    if (r_cnt == CW'(1)) begin
                        n_state = mbtcp_pkg::S_RX;
                        n_len   = 9'd0;
                    end else begin
                        n_state = mbtcp_pkg::S_RD_REQ;
                    end
                end
            end
            default: begin
                n_state = mbtcp_pkg::S_RX;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= mbtcp_pkg::S_RX;
            r_len      <= 9'd0;
            r_unit     <= mbtcp_pkg::UNIT_RESET;
            r_hvalid   <= '0;
            o_m_tvalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_len   <= n_len;
            if (i_cfg_wr_en) begin
                r_unit <= i_cfg_wr_data;
            end
            if (h_we) begin
                r_hvalid[h_waddr] <= 1'b1;
            end
            if (emit) begin
                o_m_tvalid <= 1'b1;
            end else if (i_m_tready) begin
                o_m_tvalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind <= n_kind;
        r_k    <= n_k;
        r_tx_n <= n_tx_n;
        r_exc  <= n_exc;
        r_ptr  <= n_ptr;
        r_cnt  <= n_cnt;
        r_fidx <= n_fidx;
        r_fok  <= n_fok;
        r_hvq  <= n_hvq;
        r_hi   <= n_hi;
        r_word <= n_word;
        if (in_acc && r_len < 9'(mbtcp_pkg::HDR_BYTES)) begin
            r_hdr[r_len[3:0]] <= i_s_tdata;
        end
        if (emit) begin
            o_m_tdata <= emit_byte;
            o_m_tlast <= emit_last;
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_s_tlast) |=> (r_state == mbtcp_pkg::S_DEC))
        else $error("last request item did not start decode");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == mbtcp_pkg::S_WM_WR) |-> (r_cnt != '0))
        else $error("register write with no count left");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit |-> (r_state != mbtcp_pkg::S_RX && r_state != mbtcp_pkg::S_DEC))
        else $error("response item emitted outside response states");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=>
            (o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tlast)))
        else $error("response item changed while stalled");

endmodule
